>>> src/hcbp_pkg.sv
// shared types and constants for the huffman code bit packer
package hcbp_pkg;

  // action codes of an input item
  localparam logic [1:0] ACT_LOAD   = 2'd0;
  localparam logic [1:0] ACT_ENCODE = 2'd1;
  localparam logic [1:0] ACT_FLUSH  = 2'd2;

  // most bytes one item can finish: seven pending bits plus a 32-bit code
  localparam int GRP_BYTES = 4;
  localparam int GRP_CW    = 3;

  typedef struct packed {
    logic [1:0]  action;
    logic [7:0]  symbol;
    logic [31:0] code_bits;
    logic [5:0]  code_length;
  } item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
  } result_t;

  // finished bytes handed from the packer to the output stage
  typedef struct packed {
    logic                   valid;
    logic [GRP_BYTES*8-1:0] data;
    logic [GRP_CW-1:0]      count;
  } grp_t;

endpackage

>>> src/hcbp_ram.sv
// generic single-port ram with registered read
module hcbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

>>> src/hcbp_pack.sv
// input register, code table and bit packing stage
module hcbp_pack #(
  parameter int SYMBOL_COUNT  = 256,
  parameter int MAX_CODE_BITS = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          item_valid,
  output logic          item_stall,
  input  hcbp_pkg::item_t item,
  input  logic          grp_free,
  output hcbp_pkg::grp_t  grp
);
  import hcbp_pkg::*;

  localparam int AW = $clog2(SYMBOL_COUNT);
  localparam int CW = MAX_CODE_BITS;
  localparam int LW = $clog2(CW + 1);
  localparam int WW = CW + 8;
  localparam int SW = $clog2(WW + 1);
  localparam int TW = $clog2(WW);

  logic          accept;
  logic          in_range;
  logic [LW-1:0] len_sat;
  logic [CW-1:0] code_rev;
  logic          ram_we;
  logic          ram_re;
  logic [CW+LW-1:0] ram_rdata;

  logic          s1_valid;
  logic [1:0]    s1_action;
  logic          s1_in_range;
  logic          s1_adv;
  logic          s1_emit;

  logic [7:0]    pending;
  logic [2:0]    fill;
  logic [7:0]    pending_next;
  logic [2:0]    fill_next;

  logic [CW-1:0] t_code;
  logic [LW-1:0] t_len;
  logic [SW-1:0] shamt;
  logic [WW-1:0] shifted;
  logic [7:0]    low_mask;
  logic [WW-1:0] window;
  logic [TW-1:0] total;
  logic [TW-4:0] nbytes;

  assign accept   = item_valid && !item_stall;
  assign in_range = {1'b0, item.symbol} < 9'(SYMBOL_COUNT);

  // saturate the length and store the code word bit reversed, its top bit lowest
  always_comb begin
    if (item.code_length > 6'(CW)) begin
      len_sat = LW'(CW);
    end else begin
      len_sat = LW'(item.code_length);
    end
    for (int i = 0; i < CW; i++) begin
      code_rev[i] = item.code_bits[CW-1-i];
    end
  end

  assign ram_we = accept && in_range && (item.action == ACT_LOAD);
  assign ram_re = accept && (item.action == ACT_ENCODE);

  hcbp_ram #(
    .WIDTH(CW + LW),
    .DEPTH(SYMBOL_COUNT)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .re   (ram_re),
    .addr (item.symbol[AW-1:0]),
    .wdata({len_sat, code_rev}),
    .rdata(ram_rdata)
  );

  // input register; table data arrives alongside it
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_action   <= item.action;
      s1_in_range <= in_range;
    end
  end

  // align the code above the pending bits
  assign t_code = ram_rdata[CW-1:0];
  assign t_len  = ram_rdata[CW+LW-1:CW];

  always_comb begin
    shamt    = SW'(WW) - SW'(t_len) - SW'(fill);
    shifted  = {t_code, 8'b0} >> shamt;
    low_mask = 8'((9'd1 << fill) - 9'd1);
    window   = (shifted & ~{{(WW-8){1'b0}}, low_mask}) | {{(WW-8){1'b0}}, pending};
    total    = TW'(fill) + TW'(t_len);
    nbytes   = total[TW-1:3];
  end

  // decide what the stage hands on and how the packer moves
  always_comb begin
    s1_emit      = 1'b0;
    pending_next = pending;
    fill_next    = fill;
    grp.valid    = 1'b0;
    grp.data     = (GRP_BYTES*8)'(window);
    grp.count    = GRP_CW'(nbytes);
    case (s1_action)
      ACT_ENCODE: begin
        if (s1_in_range) begin
          s1_emit      = (nbytes != '0);
          pending_next = 8'(window >> {nbytes, 3'b000});
          fill_next    = total[2:0];
        end
      end
      ACT_FLUSH: begin
        s1_emit      = (fill != 3'd0);
        grp.data     = (GRP_BYTES*8)'(pending);
        grp.count    = GRP_CW'(1);
        pending_next = 8'd0;
        fill_next    = 3'd0;
      end
      default: begin
        s1_emit = 1'b0;
      end
    endcase
    s1_adv     = !s1_valid || !s1_emit || grp_free;
    grp.valid  = s1_valid && s1_emit && grp_free;
    item_stall = !s1_adv;
  end

  // packer state
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 8'd0;
      fill    <= 3'd0;
    end else if (s1_valid && s1_adv) begin
      pending <= pending_next;
      fill    <= fill_next;
    end
  end

  // bits above the fill level stay clear
  a_pending_clean: assert property (@(posedge clk) disable iff (rst)
    (pending >> fill) == 8'd0)
    else $error("pending byte holds bits above fill level");

  // a stalled item stays in the input register
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_adv) |=> s1_valid && $stable(s1_action))
    else $error("stalled item left the input register");

endmodule

>>> src/hcbp_out.sv
// output register that sends a group of finished bytes one per transfer
module hcbp_out (
  input  logic            clk,
  input  logic            rst,
  input  hcbp_pkg::grp_t  grp,
  output logic            grp_free,
  output logic            byte_valid,
  input  logic            byte_stall,
  output hcbp_pkg::result_t byte_item
);
  import hcbp_pkg::*;

  logic [GRP_BYTES*8-1:0] data;
  logic [GRP_CW-1:0]      cnt;
  logic                   xfer;

  assign byte_valid = (cnt != '0);
  assign xfer       = byte_valid && !byte_stall;
  assign grp_free   = (cnt == '0) || ((cnt == GRP_CW'(1)) && !byte_stall);

  assign byte_item.out_byte = data[7:0];
  assign byte_item.last     = (cnt == GRP_CW'(1));

  // byte count
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (grp.valid) begin
      cnt <= grp.count;
    end else if (xfer) begin
      cnt <= cnt - GRP_CW'(1);
    end
  end

  // byte data, lowest byte goes first
  always_ff @(posedge clk) begin
    if (grp.valid) begin
      data <= grp.data;
    end else if (xfer) begin
      data <= data >> 8;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    cnt <= GRP_CW'(GRP_BYTES))
    else $error("byte count above group size");

  a_group_nonempty: assert property (@(posedge clk) disable iff (rst)
    grp.valid |=> byte_valid)
    else $error("loaded group shows no byte");

endmodule

>>> src/huffman_code_bit_packer_core.sv
// top level of the huffman code bit packer
//
//   channel  | direction | payload             | handshake
//   item     | in        | hcbp_pkg::item_t    | item_valid / item_stall
//   byte     | out       | hcbp_pkg::result_t  | byte_valid / byte_stall
//
// the table read is issued as an item is taken into the input register, so table
// data arrives with it; result bytes then come from the output register.
// an item is taken every cycle while the output stage can hold its bytes;
// an item that finishes n bytes holds the output stage until its n bytes are sent.
// a load writes the table in the cycle it is taken, so the next item sees it.
// rst is synchronous; the table is not cleared and must be loaded before use.
module huffman_code_bit_packer_core #(
  parameter int SYMBOL_COUNT  = 256,
  parameter int MAX_CODE_BITS = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  hcbp_pkg::item_t   item,
  output logic              byte_valid,
  input  logic              byte_stall,
  output hcbp_pkg::result_t byte_item
);
  import hcbp_pkg::*;

  grp_t grp;
  logic grp_free;

  // table lookup and bit packing
  hcbp_pack #(
    .SYMBOL_COUNT (SYMBOL_COUNT),
    .MAX_CODE_BITS(MAX_CODE_BITS)
  ) u_pack (
    .clk       (clk),
    .rst       (rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .item      (item),
    .grp_free  (grp_free),
    .grp       (grp)
  );

  // byte output register
  hcbp_out u_out (
    .clk       (clk),
    .rst       (rst),
    .grp       (grp),
    .grp_free  (grp_free),
    .byte_valid(byte_valid),
    .byte_stall(byte_stall),
    .byte_item (byte_item)
  );

endmodule

>>> test/tb_huffman_code_bit_packer_core.sv
// self-checking testbench for the huffman code bit packer core
module tb_huffman_code_bit_packer_core;
  timeunit 1ns;
  timeprecision 1ps;

  import hcbp_pkg::*;

  localparam int SYM_COUNT = 256;
  localparam int MAX_BITS = 32;
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  typedef enum logic [1:0] {STALL_NONE, STALL_RANDOM, STALL_PERIODIC} stall_mode_t;

  logic clk;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_stall;
  item_t item = '0;
  logic byte_valid;
  logic byte_stall = 1'b0;
  result_t byte_item;

  huffman_code_bit_packer_core #(
    .SYMBOL_COUNT (SYM_COUNT),
    .MAX_CODE_BITS(MAX_BITS)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .item      (item),
    .byte_valid(byte_valid),
    .byte_stall(byte_stall),
    .byte_item (byte_item)
  );

  // items waiting to be driven, and bytes the packer should produce
  item_t pending_items[$];
  result_t expected_bytes[$];
  int fail_count = 0;

  // predicted code table and bit accumulator
  logic [31:0] code_mem[SYM_COUNT];
  logic [5:0] len_mem[SYM_COUNT];
  logic [7:0] acc_byte = '0;
  int acc_fill = 0;

  // stimulus side bookkeeping of loaded table entries
  bit gen_loaded[SYM_COUNT];
  logic [7:0] loaded_syms[$];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
  end

  task automatic note_failure(input string msg);
    if (fail_count < 10) $display("%0t: %s", $time, msg);
    fail_count++;
  endtask

  // predict the bytes one accepted transfer causes
  task automatic pack_item(input item_t it);
    logic [31:0] code;
    int len;
    int k;
    int n_out;
    result_t r;
    n_out = 0;
    case (it.action)
      ACT_LOAD: begin
        if (it.symbol < SYM_COUNT) begin
          code_mem[it.symbol] = it.code_bits;
          len_mem[it.symbol] = (it.code_length > MAX_BITS) ? 6'(MAX_BITS) : it.code_length;
        end
      end
      ACT_ENCODE: begin
        if (it.symbol < SYM_COUNT) begin
          code = code_mem[it.symbol];
          len = len_mem[it.symbol];
          // msb of the code goes first, into the lowest free bit
          for (k = len - 1; k >= 0; k--) begin
            acc_byte[acc_fill] = code[k];
            acc_fill++;
            if (acc_fill == 8) begin
              r.out_byte = acc_byte;
              r.last = 1'b0;
              expected_bytes.push_back(r);
              n_out++;
              acc_byte = '0;
              acc_fill = 0;
            end
          end
          if (n_out > 0) begin
            r = expected_bytes.pop_back();
            r.last = 1'b1;
            expected_bytes.push_back(r);
          end
        end
      end
      ACT_FLUSH: begin
        if (acc_fill != 0) begin
          r.out_byte = acc_byte;
          r.last = 1'b1;
          expected_bytes.push_back(r);
        end
        acc_byte = '0;
        acc_fill = 0;
      end
      default: ;
    endcase
  endtask

  task automatic add_item(input logic [1:0] act, input logic [7:0] sym,
                          input logic [31:0] bits, input logic [5:0] len);
    item_t it;
    it.action = act;
    it.symbol = sym;
    it.code_bits = bits;
    it.code_length = len;
    pending_items.push_back(it);
    if (act == ACT_LOAD && !gen_loaded[sym]) begin
      gen_loaded[sym] = 1'b1;
      loaded_syms.push_back(sym);
    end
  endtask

  // sender: bursts of random length separated by random gaps
  int burst_left = 8;
  int gap_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      if (item_valid && !item_stall) pack_item(item);
      if (!item_valid || !item_stall) begin
        if (gap_left > 0 || pending_items.size() == 0) begin
          item_valid <= 1'b0;
          if (gap_left > 0) gap_left <= gap_left - 1;
        end else begin
          item <= pending_items.pop_front();
          item_valid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 24);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left <= burst_left - 1;
          end
        end
      end
    end
  end

  // receiver: stall pattern that changes mode every so often
  stall_mode_t stall_mode = STALL_NONE;
  int mode_left = 0;
  int stall_phase = 0;

  always @(posedge clk) begin
    if (rst) begin
      byte_stall <= 1'b0;
    end else begin
      stall_phase <= stall_phase + 1;
      if (mode_left == 0) begin
        stall_mode <= stall_mode_t'($urandom_range(0, 2));
        mode_left <= $urandom_range(16, 200);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        STALL_NONE:   byte_stall <= 1'b0;
        STALL_RANDOM: byte_stall <= ($urandom_range(0, 2) == 0);
        default:      byte_stall <= (stall_phase % 7) < 3;
      endcase
    end
  end

  // check every output transfer against the oldest prediction
  always @(posedge clk) begin : byte_check
    result_t want;
    if (!rst && byte_valid && !byte_stall) begin
      if (expected_bytes.size() == 0) begin
        note_failure($sformatf("unexpected byte %02h last %0b",
                               byte_item.out_byte, byte_item.last));
      end else begin
        want = expected_bytes.pop_front();
        if (byte_item.out_byte !== want.out_byte || byte_item.last !== want.last)
          note_failure($sformatf("byte mismatch: expected %02h last %0b, got %02h last %0b",
                                 want.out_byte, want.last,
                                 byte_item.out_byte, byte_item.last));
      end
    end
  end

  // stimulus, then drain and verdict
  initial begin
    int random_count;
    int roll;
    int pick;
    int len;
    int drain;

    // flush on an empty packer, unused action
    add_item(ACT_FLUSH, 8'h00, 32'h0, 6'd0);
    add_item(ACT_UNUSED, 8'hFF, 32'hFFFF_FFFF, 6'h3F);
    // table extremes: full length, saturated length, zero length, wide code value
    add_item(ACT_LOAD, 8'd0, 32'hFFFF_FFFF, 6'd32);
    add_item(ACT_LOAD, 8'd255, 32'h0000_0000, 6'd32);
    add_item(ACT_LOAD, 8'd1, 32'hA5A5_A5A5, 6'd63);
    add_item(ACT_LOAD, 8'd2, 32'hFFFF_FFFF, 6'd0);
    add_item(ACT_LOAD, 8'd3, 32'hFFFF_FFFF, 6'd3);
    add_item(ACT_LOAD, 8'd4, 32'h0000_0001, 6'd1);
    add_item(ACT_LOAD, 8'd5, 32'h0000_005A, 6'd8);
    add_item(ACT_LOAD, 8'd6, 32'h0001_2345, 6'd33);
    add_item(ACT_LOAD, 8'd7, 32'h0000_007F, 6'd7);
    add_item(ACT_ENCODE, 8'd2, 32'h0, 6'd0);
    add_item(ACT_ENCODE, 8'd4, 32'h0, 6'd0);
    add_item(ACT_ENCODE, 8'd0, 32'h0, 6'd0);
    add_item(ACT_ENCODE, 8'd1, 32'h0, 6'd0);
    add_item(ACT_ENCODE, 8'd255, 32'h0, 6'd0);
    add_item(ACT_FLUSH, 8'd0, 32'h0, 6'd0);
    add_item(ACT_FLUSH, 8'd0, 32'h0, 6'd0);
    add_item(ACT_ENCODE, 8'd5, 32'h0, 6'd0);
    add_item(ACT_ENCODE, 8'd3, 32'h0, 6'd0);
    add_item(ACT_ENCODE, 8'd3, 32'h0, 6'd0);
    add_item(ACT_ENCODE, 8'd3, 32'h0, 6'd0);
    add_item(ACT_ENCODE, 8'd6, 32'h0, 6'd0);
    // seven bits complete the pending byte, then a 32-bit code
    add_item(ACT_ENCODE, 8'd7, 32'h0, 6'd0);
    add_item(ACT_ENCODE, 8'd0, 32'h0, 6'd0);
    add_item(ACT_FLUSH, 8'd0, 32'h0, 6'd0);

    // random mix: mostly encodes of loaded symbols, some loads and flushes, a few unused actions
    random_count = 0;
    while (random_count < 330) begin
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
        add_item(ACT_UNUSED, 8'($urandom), $urandom, 6'($urandom));
      end else begin
        random_count++;
        if (roll < 14 || loaded_syms.size() == 0) begin
          pick = $urandom_range(0, 9);
          if (pick < 6) len = $urandom_range(1, 12);
          else if (pick < 9) len = $urandom_range(13, 32);
          else len = $urandom_range(0, 63);
          add_item(ACT_LOAD, 8'($urandom), $urandom, 6'(len));
        end else if (roll < 22) begin
          add_item(ACT_FLUSH, 8'($urandom), $urandom, 6'($urandom));
        end else begin
          add_item(ACT_ENCODE, loaded_syms[$urandom_range(0, loaded_syms.size() - 1)],
                   $urandom, 6'($urandom));
        end
      end
    end

    @(posedge clk);
    while (rst || pending_items.size() != 0 || item_valid) @(posedge clk);
    for (drain = 0; drain < 100000 && expected_bytes.size() != 0; drain++) @(posedge clk);
    repeat (16) @(posedge clk);
    if (expected_bytes.size() != 0)
      note_failure($sformatf("%0d expected bytes never arrived", expected_bytes.size()));

    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // hard stop if the run hangs
  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
